// File: design/lwsc_pkg.sv
package lwsc_pkg;

   localparam int SLOTS_DEFAULT = 64;
   localparam int OPCODE_W      = 2;
   localparam int SECTOR_W      = 32;
   localparam int SLOT_W        = 6;
   localparam int STAMP_W       = 64;

   typedef enum logic [OPCODE_W-1:0] {
      OP_READ     = 2'd0,
      OP_WRITE    = 2'd1,
      OP_PREFETCH = 2'd2,
      OP_FLUSH    = 2'd3
   } opcode_type;

   typedef logic [SLOT_W-1:0]   slot_type;
   typedef logic [SECTOR_W-1:0] sector_type;
   typedef logic [STAMP_W-1:0]  stamp_type;

   // one slot as held in the tag ram
   typedef struct packed {
      sector_type tag;
      logic       dirty;
      stamp_type  stamp;
   } entry_type;

   typedef struct packed {
      slot_type   slot;
      logic       hit;
      logic       fill_needed;
      logic       writeback;
      sector_type writeback_sector;
      logic       last;
   } rsp_type;

   typedef enum logic [1:0] {
      ST_IDLE   = 2'd0,
      ST_SCAN   = 2'd1,
      ST_FINISH = 2'd2
   } state_type;

endpackage

// File: design/lwsc_req_if.sv
interface lwsc_req_if;
   logic                              valid;
   logic                              ready;
   logic [lwsc_pkg::OPCODE_W-1:0]     opcode;
   logic [lwsc_pkg::SECTOR_W-1:0]     sector;

   modport source (output valid, output opcode, output sector, input ready);
   modport sink   (input valid, input opcode, input sector, output ready);
endinterface

// File: design/lwsc_rsp_if.sv
interface lwsc_rsp_if;
   logic                              valid;
   logic                              ready;
   logic [lwsc_pkg::SLOT_W-1:0]       slot;
   logic                              hit;
   logic                              fill_needed;
   logic                              writeback;
   logic [lwsc_pkg::SECTOR_W-1:0]     writeback_sector;
   logic                              last;

   modport source (output valid, output slot, output hit, output fill_needed,
                   output writeback, output writeback_sector, output last,
                   input ready);
   modport sink   (input valid, input slot, input hit, input fill_needed,
                   input writeback, input writeback_sector, input last,
                   output ready);
endinterface

// File: design/lru_write_back_sector_cache_unit.sv
// Tag and replacement controller for a fully associative LRU write-back sector cache.
// req_chan carries one request per transfer: opcode (read, write, prefetch, flush all)
// and sector. rsp_chan returns the results; an access gives one result, a flush gives
// one per dirty slot in ascending slot order (or a single empty one), last marks the
// final result of a request.
// Slot tags, dirty marks and LRU stamps sit in one ram with a registered read. Each
// request other than a prefetch of sector zero walks the valid slots (at most SLOTS,
// 64 by default) one per cycle while no stall holds the walk; a hit ends the walk at
// the matching slot. A new request is taken once the previous one has issued all
// of its results.
// Reset empties the cache at once: a fill count tracks which slots hold a sector, so
// no clearing pass runs. The LRU counter restarts from zero.
// One result waits in the output register while the next request is walked; if the
// receiver stalls and a further result is due, the walk holds until the output
// register drains.
module lru_write_back_sector_cache_unit #(
   parameter int SLOTS = lwsc_pkg::SLOTS_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   lwsc_req_if.sink   req_chan,
   lwsc_rsp_if.source rsp_chan
);

   localparam int IDX_W = $clog2(SLOTS);
   localparam int ENT_W = $bits(lwsc_pkg::entry_type);

   logic              out_free;
   logic              rsp_load;
   lwsc_pkg::rsp_type rsp_next;
   logic              rsp_valid_ff, rsp_valid_in;
   lwsc_pkg::rsp_type rsp_data_ff, rsp_data_in;

   logic [IDX_W-1:0]  rd_addr;
   logic [ENT_W-1:0]  rd_data;
   logic              wr_en;
   logic [IDX_W-1:0]  wr_addr;
   logic [ENT_W-1:0]  wr_data;

   lwsc_ram #(
      .WIDTH (ENT_W),
      .DEPTH (SLOTS)
   ) u_tag_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   lwsc_ctrl #(
      .SLOTS (SLOTS)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_chan.valid),
      .req_opcode (req_chan.opcode),
      .req_sector (req_chan.sector),
      .req_ready  (req_chan.ready),
      .out_free   (out_free),
      .rsp_load   (rsp_load),
      .rsp_data   (rsp_next),
      .rd_addr    (rd_addr),
      .rd_data    (rd_data),
      .wr_en      (wr_en),
      .wr_addr    (wr_addr),
      .wr_data    (wr_data)
   );

   // output register: free when empty or being taken this cycle
   assign out_free     = !rsp_valid_ff || rsp_chan.ready;
   assign rsp_valid_in = rsp_load || (rsp_valid_ff && !rsp_chan.ready);
   assign rsp_data_in  = rsp_load ? rsp_next : rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_chan.valid            = rsp_valid_ff;
   assign rsp_chan.slot             = rsp_data_ff.slot;
   assign rsp_chan.hit              = rsp_data_ff.hit;
   assign rsp_chan.fill_needed      = rsp_data_ff.fill_needed;
   assign rsp_chan.writeback        = rsp_data_ff.writeback;
   assign rsp_chan.writeback_sector = rsp_data_ff.writeback_sector;
   assign rsp_chan.last             = rsp_data_ff.last;

   a_load_into_free: assert property (@(posedge clock) disable iff (reset)
      rsp_load |-> out_free)
      else $error("result loaded over a waiting result");

   a_busy_after_request: assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready) |=> !req_chan.ready)
      else $error("request taken while the previous one is in progress");

   a_hit_is_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_load && rsp_next.hit) |-> (!rsp_next.fill_needed && !rsp_next.writeback))
      else $error("hit reported together with fill or write-back");

endmodule

// File: design/lwsc_ram.sv
module lwsc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64,
   localparam int AW   = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

// File: design/lwsc_ctrl.sv
module lwsc_ctrl #(
   parameter int SLOTS = lwsc_pkg::SLOTS_DEFAULT,
   localparam int IDX_W = $clog2(SLOTS),
   localparam int CNT_W = $clog2(SLOTS + 1),
   localparam int ENT_W = $bits(lwsc_pkg::entry_type)
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   input  logic [lwsc_pkg::OPCODE_W-1:0] req_opcode,
   input  lwsc_pkg::sector_type          req_sector,
   output logic                          req_ready,
   input  logic                          out_free,
   output logic                          rsp_load,
   output lwsc_pkg::rsp_type             rsp_data,
   output logic [IDX_W-1:0]              rd_addr,
   input  logic [ENT_W-1:0]              rd_data,
   output logic                          wr_en,
   output logic [IDX_W-1:0]              wr_addr,
   output logic [ENT_W-1:0]              wr_data
);

   lwsc_pkg::state_type  state_ff, state_in;
   lwsc_pkg::opcode_type op_ff, op_in;
   lwsc_pkg::sector_type sector_ff, sector_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   lwsc_pkg::stamp_type  counter_ff, counter_in;
   logic [IDX_W-1:0]     idx_ff, idx_in;
   lwsc_pkg::stamp_type  min_stamp_ff, min_stamp_in;
   logic [IDX_W-1:0]     vic_idx_ff, vic_idx_in;
   lwsc_pkg::sector_type vic_tag_ff, vic_tag_in;
   logic                 vic_dirty_ff, vic_dirty_in;
   logic                 pend_valid_ff, pend_valid_in;
   logic [IDX_W-1:0]     pend_idx_ff, pend_idx_in;
   lwsc_pkg::sector_type pend_tag_ff, pend_tag_in;

   lwsc_pkg::entry_type  rd_entry;
   lwsc_pkg::entry_type  wr_entry;
   logic                 accept;
   logic                 req_pf_zero;
   logic                 is_flush;
   logic                 hit;
   logic                 last_entry;
   logic                 stall;
   logic                 alloc;
   logic [IDX_W-1:0]     chosen;

   assign rd_entry    = lwsc_pkg::entry_type'(rd_data);
   assign wr_data     = ENT_W'(wr_entry);
   assign req_ready   = (state_ff == lwsc_pkg::ST_IDLE);
   assign accept      = req_valid && req_ready;
   assign req_pf_zero = (req_opcode == lwsc_pkg::OP_PREFETCH) && (req_sector == '0);
   assign is_flush    = (op_ff == lwsc_pkg::OP_FLUSH);
   assign hit         = !is_flush && (rd_entry.tag == sector_ff);
   // slots are allocated in order and never freed, so the valid ones are 0 .. count-1
   assign last_entry  = (CNT_W'(idx_ff) + CNT_W'(1)) == count_ff;
   // a result has nowhere to go: hold the walk and read the same entry again
   assign stall       = (hit || (is_flush && rd_entry.dirty && pend_valid_ff)) && !out_free;
   assign alloc       = (count_ff != CNT_W'(SLOTS));
   assign chosen      = alloc ? count_ff[IDX_W-1:0] : vic_idx_ff;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         lwsc_pkg::ST_IDLE: begin
            if (accept) begin
               if (req_pf_zero || (count_ff == '0)) begin
                  state_in = lwsc_pkg::ST_FINISH;
               end else begin
                  state_in = lwsc_pkg::ST_SCAN;
               end
            end
         end
         lwsc_pkg::ST_SCAN: begin
            if (!stall) begin
               if (hit) begin
                  state_in = lwsc_pkg::ST_IDLE;
               end else if (last_entry) begin
                  state_in = lwsc_pkg::ST_FINISH;
               end
            end
         end
         lwsc_pkg::ST_FINISH: begin
            if (out_free) begin
               state_in = lwsc_pkg::ST_IDLE;
            end
         end
         default: state_in = lwsc_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      op_in         = op_ff;
      sector_in     = sector_ff;
      count_in      = count_ff;
      counter_in    = counter_ff;
      idx_in        = idx_ff;
      min_stamp_in  = min_stamp_ff;
      vic_idx_in    = vic_idx_ff;
      vic_tag_in    = vic_tag_ff;
      vic_dirty_in  = vic_dirty_ff;
      pend_valid_in = pend_valid_ff;
      pend_idx_in   = pend_idx_ff;
      pend_tag_in   = pend_tag_ff;
      rd_addr       = idx_ff;
      wr_en         = 1'b0;
      wr_addr       = idx_ff;
      wr_entry      = rd_entry;
      rsp_load      = 1'b0;
      rsp_data      = '0;
      unique case (state_ff)
         lwsc_pkg::ST_IDLE: begin
            rd_addr = '0;
            idx_in  = '0;
            if (accept) begin
               op_in         = lwsc_pkg::opcode_type'(req_opcode);
               sector_in     = req_sector;
               pend_valid_in = 1'b0;
            end
         end
         lwsc_pkg::ST_SCAN: begin
            if (!stall) begin
               if (is_flush) begin
                  if (rd_entry.dirty) begin
                     wr_en          = 1'b1;
                     wr_entry.dirty = 1'b0;
                     // the previous dirty slot is now known not to be the final one
                     if (pend_valid_ff) begin
                        rsp_load                  = 1'b1;
                        rsp_data.slot             = lwsc_pkg::slot_type'(pend_idx_ff);
                        rsp_data.writeback        = 1'b1;
                        rsp_data.writeback_sector = pend_tag_ff;
                     end
                     pend_valid_in = 1'b1;
                     pend_idx_in   = idx_ff;
                     pend_tag_in   = rd_entry.tag;
                  end
               end else if (hit) begin
                  wr_en            = 1'b1;
                  wr_entry.dirty   = rd_entry.dirty || (op_ff == lwsc_pkg::OP_WRITE);
                  wr_entry.stamp   = counter_ff;
                  counter_in       = counter_ff + lwsc_pkg::stamp_type'(1);
                  rsp_load         = 1'b1;
                  rsp_data.slot    = lwsc_pkg::slot_type'(idx_ff);
                  rsp_data.hit     = 1'b1;
                  rsp_data.last    = 1'b1;
               end else if ((idx_ff == '0) || (rd_entry.stamp < min_stamp_ff)) begin
                  min_stamp_in = rd_entry.stamp;
                  vic_idx_in   = idx_ff;
                  vic_tag_in   = rd_entry.tag;
                  vic_dirty_in = rd_entry.dirty;
               end
               if (!last_entry) begin
                  idx_in  = idx_ff + IDX_W'(1);
                  rd_addr = idx_ff + IDX_W'(1);
               end
            end
         end
         lwsc_pkg::ST_FINISH: begin
            if (out_free) begin
               rsp_load      = 1'b1;
               rsp_data.last = 1'b1;
               if (is_flush) begin
                  if (pend_valid_ff) begin
                     rsp_data.slot             = lwsc_pkg::slot_type'(pend_idx_ff);
                     rsp_data.writeback        = 1'b1;
                     rsp_data.writeback_sector = pend_tag_ff;
                  end
                  pend_valid_in = 1'b0;
               end else if (!((op_ff == lwsc_pkg::OP_PREFETCH) && (sector_ff == '0))) begin
                  wr_en                = 1'b1;
                  wr_addr              = chosen;
                  wr_entry.tag         = sector_ff;
                  wr_entry.dirty       = (op_ff == lwsc_pkg::OP_WRITE);
                  wr_entry.stamp       = counter_ff;
                  counter_in           = counter_ff + lwsc_pkg::stamp_type'(1);
                  if (alloc) begin
                     count_in = count_ff + CNT_W'(1);
                  end
                  rsp_data.slot        = lwsc_pkg::slot_type'(chosen);
                  rsp_data.fill_needed = 1'b1;
                  rsp_data.writeback   = !alloc && vic_dirty_ff;
                  if (!alloc && vic_dirty_ff) begin
                     rsp_data.writeback_sector = vic_tag_ff;
                  end
               end
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= lwsc_pkg::ST_IDLE;
         count_ff      <= '0;
         counter_ff    <= '0;
         pend_valid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         counter_ff    <= counter_in;
         pend_valid_ff <= pend_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff        <= op_in;
      sector_ff    <= sector_in;
      idx_ff       <= idx_in;
      min_stamp_ff <= min_stamp_in;
      vic_idx_ff   <= vic_idx_in;
      vic_tag_ff   <= vic_tag_in;
      vic_dirty_ff <= vic_dirty_in;
      pend_idx_ff  <= pend_idx_in;
      pend_tag_ff  <= pend_tag_in;
   end

endmodule
